// ===== hw/rtl/mac_learning_forward_table_top_defines.svh =====
// Assertion macros shared by the forwarding table RTL.
`ifndef MAC_LEARNING_FORWARD_TABLE_TOP_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define MLFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante.
`define MLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLFT_ASSERT_SAME(lbl, ante, cons, msg)
`define MLFT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/mlft_pkg.sv =====
// Types and field widths of the MAC learning forwarding table.
`timescale 1ns / 1ps
`default_nettype none

package mlft_pkg;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned PORT_W  = 5;
    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned M_DATA_W = 8;

    typedef logic [MAC_W-1:0]  mac_t;
    typedef logic [PORT_W-1:0] port_t;

    typedef struct packed {
        port_t ingress_port;
        mac_t  dst_mac;
        mac_t  src_mac;
    } in_item_t;

    typedef struct packed {
        logic  learn_dropped;
        logic  flood;
        port_t forward_port;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mac_learning_forward_table_top.sv =====
// Learning forwarding table: learn the source, look up the destination, one frame per cycle.
// Path: an accepted input transaction is held in the input register, then passes to the result
//   register fed by the parallel table compare, which drives m_axis_tvalid.
// Throughput: 1 frame header per cycle while m_axis_tready stays high; update and lookup of a
//   frame happen between the two registers, so the next frame sees the updated table.
// Reset: synchronous on aresetn low; clears all entry valid bits and both pipeline stages at
//   once. No clearing pass; the table is usable in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "mac_learning_forward_table_top_defines.svh"

module mac_learning_forward_table_top #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned PORT_COUNT    = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [47:0] src_mac, [95:48] dst_mac, [100:96] ingress_port, [103:101] zero
    input  wire logic [mlft_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [4:0] forward_port, [5] flood, [6] learn_dropped, [7] zero
    output logic [mlft_pkg::M_DATA_W-1:0]       m_axis_tdata
);

    // Table storage: one register per entry, every entry compared in parallel.
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [TABLE_ENTRIES-1:0] entry_valid_next;
    mlft_pkg::mac_t           entry_mac_reg  [TABLE_ENTRIES];
    mlft_pkg::port_t          entry_port_reg [TABLE_ENTRIES];

    // Pipeline stages.
    logic                 in_valid_reg;
    mlft_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    mlft_pkg::out_item_t  out_item_reg;
    mlft_pkg::out_item_t  out_item_next;

    logic advance;
    logic commit;

    // Lookup and learn logic.
    logic                     learn_en;
    logic [TABLE_ENTRIES-1:0] src_hit_vec;
    logic [TABLE_ENTRIES-1:0] dst_hit_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] free_onehot;
    logic [TABLE_ENTRIES-1:0] write_vec;
    logic                     src_known;
    logic                     table_full;
    logic                     learn_drop;
    logic                     self_hit;
    mlft_pkg::port_t          dst_port_old;

    // Move the result register when it is empty or being taken; fill the
    // input register when it is empty or its content moves on.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign commit        = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Learn only for a real ingress port.
    assign learn_en = (in_item_reg.ingress_port != '0) &&
                      (in_item_reg.ingress_port <= mlft_pkg::PORT_W'(PORT_COUNT));

    always_comb begin
        dst_port_old = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            src_hit_vec[i] = entry_valid_reg[i] && (entry_mac_reg[i] == in_item_reg.src_mac);
            dst_hit_vec[i] = entry_valid_reg[i] && (entry_mac_reg[i] == in_item_reg.dst_mac);
            dst_port_old   = dst_port_old | (dst_hit_vec[i] ? entry_port_reg[i] : '0);
        end
    end

    // Isolate the lowest free entry with a two's-complement mask.
    assign free_vec    = ~entry_valid_reg;
    assign free_onehot = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    assign src_known   = |src_hit_vec;
    assign table_full  = &entry_valid_reg;
    assign learn_drop  = learn_en && !src_known && table_full;

    always_comb begin
        priority if (!learn_en) begin
            write_vec = '0;
        end else if (src_known) begin
            write_vec = src_hit_vec;
        end else begin
            write_vec = free_onehot;
        end
    end

    assign entry_valid_next = entry_valid_reg | (commit ? write_vec : '0);

    // A destination equal to a freshly learned source sees this frame's port.
    assign self_hit = learn_en && !learn_drop && (in_item_reg.src_mac == in_item_reg.dst_mac);

    always_comb begin
        out_item_next.learn_dropped = learn_drop;
        priority if (self_hit) begin
            out_item_next.forward_port = in_item_reg.ingress_port;
            out_item_next.flood        = 1'b0;
        end else if (|dst_hit_vec) begin
            out_item_next.forward_port = dst_port_old;
            out_item_next.flood        = 1'b0;
        end else begin
            out_item_next.forward_port = '0;
            out_item_next.flood        = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Payload: hold while stalled, no reset.
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.src_mac      <= s_axis_tdata[47:0];
            in_item_reg.dst_mac      <= s_axis_tdata[95:48];
            in_item_reg.ingress_port <= s_axis_tdata[100:96];
        end
        if (commit) begin
            out_item_reg <= out_item_next;
        end
    end

    // Table contents: write the learned entry when the frame commits.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (commit && write_vec[i]) begin
                entry_mac_reg[i]  <= in_item_reg.src_mac;
                entry_port_reg[i] <= in_item_reg.ingress_port;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_item_reg.learn_dropped, out_item_reg.flood,
                            out_item_reg.forward_port};

    // A MAC is stored in at most one valid entry.
    `MLFT_ASSERT_SAME(a_src_unique, in_valid_reg, $onehot0(src_hit_vec), "duplicate source entry")
    `MLFT_ASSERT_SAME(a_dst_unique, in_valid_reg, $onehot0(dst_hit_vec), "duplicate dest entry")
    // A commit claims at most one new entry.
    `MLFT_ASSERT_SAME(a_one_alloc, 1'b1,
        $onehot0(entry_valid_next ^ entry_valid_reg), "multi alloc")
    // Entries are never removed.
    `MLFT_ASSERT_NEXT(a_no_evict, 1'b1,
        (entry_valid_reg & $past(entry_valid_reg)) == $past(entry_valid_reg), "entry lost")
    // A dropped learn only happens with a full table.
    `MLFT_ASSERT_SAME(a_drop_full, commit && learn_drop, &entry_valid_reg, "drop with free entry")

endmodule

`default_nettype wire

// ===== bench/tb_mac_learning_forward_table_top.sv =====
// Testbench for the MAC learning forwarding table: stream stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module tb_mac_learning_forward_table_top;

    localparam int unsigned ENTRIES       = 64;
    localparam int unsigned PORTS         = 16;
    localparam int unsigned RANDOM_FRAMES = 1700;
    localparam int unsigned POOL_SIZE     = 96;
    localparam int unsigned DRAIN_CYCLES  = 8;

    localparam mlft_pkg::mac_t MAC_ZERO = 48'h0000_0000_0000;
    localparam mlft_pkg::mac_t MAC_ONES = 48'hFFFF_FFFF_FFFF;
    localparam mlft_pkg::mac_t MAC_A    = 48'h0A1B_2C3D_4E5F;
    localparam mlft_pkg::mac_t MAC_ALT  = 48'hAAAA_AAAA_AAAA;
    localparam mlft_pkg::mac_t MAC_ALT5 = 48'h5555_5555_5555;

    // Mirror of the switch table; predicts the forwarding decision of every accepted frame
    // and holds those decisions in arrival order until the block returns them.
    class forward_table_checker;
        bit                  slot_valid[ENTRIES];
        mlft_pkg::mac_t      slot_mac[ENTRIES];
        mlft_pkg::port_t     slot_port[ENTRIES];
        mlft_pkg::out_item_t expected_forwards[$];
        int unsigned         mismatches;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            mismatches = 0;
        endfunction

        function int find_slot(mlft_pkg::mac_t mac);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && slot_mac[i] == mac) return i;
            return -1;
        endfunction

        // Learn the source, then look up the destination in the updated table.
        function mlft_pkg::out_item_t predict_forward(mlft_pkg::in_item_t frame);
            mlft_pkg::out_item_t res;
            int                  idx;
            res = '0;
            if (frame.ingress_port != 0 && frame.ingress_port <= PORTS) begin
                idx = find_slot(frame.src_mac);
                if (idx < 0) begin
                    for (int i = 0; i < ENTRIES && idx < 0; i++)
                        if (!slot_valid[i]) idx = i;
                    if (idx >= 0) begin
                        slot_valid[idx] = 1'b1;
                        slot_mac[idx]   = frame.src_mac;
                    end
                end
                if (idx >= 0)
                    slot_port[idx] = frame.ingress_port;
                else
                    res.learn_dropped = 1'b1;
            end
            idx = find_slot(frame.dst_mac);
            if (idx >= 0)
                res.forward_port = slot_port[idx];
            else
                res.flood = 1'b1;
            return res;
        endfunction

        function void note_frame(mlft_pkg::in_item_t frame);
            expected_forwards.insert(expected_forwards.size(), predict_forward(frame));
        endfunction

        function void check_forward(mlft_pkg::out_item_t got);
            mlft_pkg::out_item_t exp;
            if (expected_forwards.size() == 0) begin
                $error("unexpected result transaction: tdata %0h", got);
                mismatches++;
                return;
            end
            exp = expected_forwards.pop_front();
            if (got.forward_port !== exp.forward_port) begin
                $error("forward_port: expected %0d, got %0d", exp.forward_port, got.forward_port);
                mismatches++;
            end
            if (got.flood !== exp.flood) begin
                $error("flood: expected %0d, got %0d", exp.flood, got.flood);
                mismatches++;
            end
            if (got.learn_dropped !== exp.learn_dropped) begin
                $error("learn_dropped: expected %0d, got %0d",
                       exp.learn_dropped, got.learn_dropped);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_forwards.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // [47:0] src_mac, [95:48] dst_mac, [100:96] ingress_port, [103:101] zero
    logic [mlft_pkg::S_DATA_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // [4:0] forward_port, [5] flood, [6] learn_dropped, [7] zero
    logic [mlft_pkg::M_DATA_W-1:0] m_axis_tdata;

    forward_table_checker  fwd_board;
    mlft_pkg::mac_t        mac_pool[POOL_SIZE];
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;

    mac_learning_forward_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver: decide backpressure at every falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check every result transaction at the rising edge it completes on.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            fwd_board.check_forward(mlft_pkg::out_item_t'(m_axis_tdata[6:0]));
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #5_000_000;
        $display("mac_learning_forward_table_top verification failed");
        $finish;
    end

    function automatic mlft_pkg::mac_t random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic mlft_pkg::in_item_t make_frame(mlft_pkg::mac_t src, mlft_pkg::mac_t dst,
                                                      mlft_pkg::port_t port);
        mlft_pkg::in_item_t f;
        f.src_mac      = src;
        f.dst_mac      = dst;
        f.ingress_port = port;
        return f;
    endfunction

    // Mostly known hosts on real ports, with fresh hosts, local frames and bogus ports mixed in.
    // The pool limit grows with the frame count so the table fills and then overflows.
    function automatic mlft_pkg::in_item_t random_frame(int unsigned pool_lim);
        mlft_pkg::in_item_t f;
        int unsigned        r;
        f.src_mac = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(pool_lim - 1)]
                                              : random_mac();
        r = $urandom_range(99);
        if (r < 75)
            f.ingress_port = mlft_pkg::port_t'($urandom_range(PORTS, 1));
        else if (r < 87)
            f.ingress_port = '0;
        else
            f.ingress_port = mlft_pkg::port_t'($urandom_range(31, PORTS + 1));
        r = $urandom_range(99);
        if (r < 60)
            f.dst_mac = mac_pool[$urandom_range(pool_lim - 1)];
        else if (r < 75)
            f.dst_mac = f.src_mac;
        else
            f.dst_mac = random_mac();
        return f;
    endfunction

    // Present one frame and hold it until accepted; call and return at a falling edge.
    task automatic send_frame(input mlft_pkg::in_item_t frame);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, frame};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        fwd_board.note_frame(frame);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (fwd_board.pending() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        fwd_board      = new();
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 18;
        recv_stall_pct = 68;
        foreach (mac_pool[i]) mac_pool[i] = random_mac();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames on an empty table.
        send_frame(make_frame(MAC_A, MAC_A, 5'd0));      // local frame: no learning, flood
        send_frame(make_frame(MAC_A, MAC_A, 5'd17));     // port past the last real one
        send_frame(make_frame(MAC_A, MAC_A, 5'd31));     // highest port code, still ignored
        send_frame(make_frame(MAC_A, MAC_A, 5'd1));      // source equals destination
        send_frame(make_frame(MAC_ONES, MAC_A, 5'd16));  // all-ones MAC on the top port
        send_frame(make_frame(MAC_ZERO, MAC_ONES, 5'd5)); // all-zero MAC learned
        send_frame(make_frame(MAC_A, MAC_ZERO, 5'd9));   // known source moves to a new port
        send_frame(make_frame(MAC_ALT, MAC_A, 5'd0));    // lookup still runs without learning
        send_frame(make_frame(MAC_ALT, MAC_ALT, 5'd17)); // bogus port left it unlearned
        send_frame(make_frame(MAC_ALT5, MAC_ALT, 5'd2)); // destination miss
        send_frame(make_frame(MAC_ALT, MAC_ALT5, 5'd3));
        send_frame(make_frame(MAC_ONES, MAC_ONES, 5'd4));
        send_frame(make_frame(random_mac(), MAC_ZERO, 5'd0));
        send_frame(make_frame(MAC_ZERO, MAC_ALT, 5'd8));
        send_frame(make_frame(MAC_ALT5, MAC_ONES, 5'd15));
        send_frame(make_frame(MAC_ALT5, MAC_ALT5, 5'd10));
        send_frame(make_frame(random_mac(), random_mac(), 5'd7));
        send_frame(make_frame(MAC_A, MAC_A, 5'd16));

        // Sender pause: let the pipeline empty completely before the random part.
        wait_for_results();

        // Three idle profiles: sender light / receiver heavy, swapped, then none.
        for (int phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0: begin send_idle_pct = 18; recv_stall_pct = 68; end
                1: begin send_idle_pct = 68; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_FRAMES / 3; n++) begin
                int unsigned lim;
                lim = 16 + (phase * (RANDOM_FRAMES / 3) + n) / 10;
                if (lim > POOL_SIZE) lim = POOL_SIZE;
                send_frame(random_frame(lim));
            end
            wait_for_results();
        end

        // Catch any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fwd_board.mismatches == 0 && fwd_board.pending() == 0)
            $display("mac_learning_forward_table_top verification clean");
        else
            $display("mac_learning_forward_table_top verification failed");
        $finish;
    end

endmodule
